// ===== rtl/core/texel_format_expander_unit_macros.svh =====
// ---------------------------------------------------------------------------
// texel format expander assertion macros
// shared concurrent assertion wrappers for the expander core
// ---------------------------------------------------------------------------
`ifndef TEXEL_FORMAT_EXPANDER_UNIT_MACROS_SVH
`define TEXEL_FORMAT_EXPANDER_UNIT_MACROS_SVH

// explicit clock and reset
`define TFE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// default clock and reset of the core
`define TFE_ASSERT(lbl, prop, msg) \
  `TFE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/tfe_pkg.sv =====
// ---------------------------------------------------------------------------
// texel format expander package
// format codes and the types passed between front, queue and back
// ---------------------------------------------------------------------------
package tfe_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned WordW = 32;
  localparam int unsigned FmtW = 4;

  typedef enum logic [FmtW-1:0] {
    FmtRgba8    = 4'd0,
    FmtRgb8     = 4'd1,
    FmtRgba5551 = 4'd2,
    FmtRgb565   = 4'd3,
    FmtRgba4    = 4'd4,
    FmtLa8      = 4'd5,
    FmtHilo8    = 4'd6,
    FmtL8       = 4'd7,
    FmtA8       = 4'd8,
    FmtLa4      = 4'd9,
    FmtL4       = 4'd10,
    FmtA4       = 4'd11
  } fmt_e;

  typedef struct packed {
    fmt_e             fmt;
    logic [WordW-1:0] word;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== rtl/core/tfe_front.sv =====
// ---------------------------------------------------------------------------
// texel format expander front
// holds the format register, accepts texels and drops undefined formats
// ---------------------------------------------------------------------------
module tfe_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tfe_pkg::FmtW-1:0]  cfg_wdata_i,
  input  logic                      start_i,
  input  logic [tfe_pkg::WordW-1:0] source_word_i,
  input  logic                      full_i,
  output logic                      busy_o,
  output tfe_pkg::push_t            push_o
);

  logic [tfe_pkg::FmtW-1:0] fmt_q;
  logic [tfe_pkg::FmtW-1:0] fmt_d;
  logic                     fmt_ok;

  always_comb begin
    fmt_d = fmt_q;
    if (cfg_we_i) begin
      fmt_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= tfe_pkg::FmtRgba8;
    end else begin
      fmt_q <= fmt_d;
    end
  end

  assign fmt_ok = (fmt_q <= tfe_pkg::FmtA4);
  assign busy_o = full_i;

  always_comb begin
    push_o.push       = start_i && !full_i && fmt_ok;
    push_o.entry.fmt  = tfe_pkg::fmt_e'(fmt_q);
    push_o.entry.word = source_word_i;
  end

endmodule

// ===== rtl/core/tfe_queue.sv =====
// ---------------------------------------------------------------------------
// texel format expander queue
// short fifo of classified texels between front and back
// ---------------------------------------------------------------------------
`include "texel_format_expander_unit_macros.svh"

module tfe_queue #(
  parameter int unsigned Depth = tfe_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfe_pkg::push_t push_i,
  input  logic           pop_i,
  output tfe_pkg::head_t head_o,
  output logic           full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  tfe_pkg::entry_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntFull);
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_comb begin
    head_o.valid = (count_q != '0);
    head_o.entry = mem_q[rd_ptr_q];
  end

  `TFE_ASSERT(a_count_bound, count_q <= CntFull, "queue count beyond depth")
  `TFE_ASSERT(a_pop_nonempty, pop_i |-> (count_q != '0), "pop from empty queue")

endmodule

// ===== rtl/core/tfe_back.sv =====
// ---------------------------------------------------------------------------
// texel format expander back
// widens the queued texel into rgba8 pixels, one pixel per cycle
// ---------------------------------------------------------------------------
`include "texel_format_expander_unit_macros.svh"

module tfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfe_pkg::head_t head_i,
  output logic           pop_o,
  output logic           result_valid_o,
  output logic [7:0]     alpha_out_o,
  output logic [7:0]     blue_out_o,
  output logic [7:0]     green_out_o,
  output logic [7:0]     red_out_o,
  output logic           run_end_o
);

  function automatic logic [7:0] widen1(input logic v);
    return {8{v}};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  logic        half_q, half_d;
  logic        valid_q, valid_d;
  logic        run_end_q, run_end_d;
  logic [7:0]  a_q, b_q, g_q, r_q;
  logic [7:0]  a_d, b_d, g_d, r_d;
  logic        two_pix;
  logic [3:0]  nib;
  logic [15:0] h;
  logic [7:0]  b0, b1, b2, b3;

  assign h  = head_i.entry.word[15:0];
  assign b0 = head_i.entry.word[7:0];
  assign b1 = head_i.entry.word[15:8];
  assign b2 = head_i.entry.word[23:16];
  assign b3 = head_i.entry.word[31:24];
  assign two_pix = (head_i.entry.fmt == tfe_pkg::FmtL4) ||
                   (head_i.entry.fmt == tfe_pkg::FmtA4);
  // low nibble first, high nibble on the second pixel
  assign nib = half_q ? b0[7:4] : b0[3:0];

  always_comb begin
    a_d = '0;
    b_d = '0;
    g_d = '0;
    r_d = '0;
    unique case (head_i.entry.fmt)
      tfe_pkg::FmtRgba8: begin
        a_d = b0; b_d = b1; g_d = b2; r_d = b3;
      end
      tfe_pkg::FmtRgb8: begin
        a_d = 8'hFF; b_d = b0; g_d = b1; r_d = b2;
      end
      tfe_pkg::FmtRgba5551: begin
        a_d = widen1(h[0]); b_d = widen5(h[5:1]);
        g_d = widen5(h[10:6]); r_d = widen5(h[15:11]);
      end
      tfe_pkg::FmtRgb565: begin
        a_d = 8'hFF; b_d = widen5(h[4:0]);
        g_d = widen6(h[10:5]); r_d = widen5(h[15:11]);
      end
      tfe_pkg::FmtRgba4: begin
        a_d = widen4(h[3:0]); b_d = widen4(h[7:4]);
        g_d = widen4(h[11:8]); r_d = widen4(h[15:12]);
      end
      tfe_pkg::FmtLa8: begin
        a_d = b0; b_d = b1; g_d = b1; r_d = b1;
      end
      tfe_pkg::FmtHilo8: begin
        a_d = 8'hFF; g_d = b0; r_d = b1;
      end
      tfe_pkg::FmtL8: begin
        a_d = 8'hFF; b_d = b0; g_d = b0; r_d = b0;
      end
      tfe_pkg::FmtA8: begin
        a_d = b0;
      end
      tfe_pkg::FmtLa4: begin
        a_d = widen4(b0[3:0]); b_d = widen4(b0[7:4]);
        g_d = widen4(b0[7:4]); r_d = widen4(b0[7:4]);
      end
      tfe_pkg::FmtL4: begin
        a_d = 8'hFF; b_d = widen4(nib); g_d = widen4(nib); r_d = widen4(nib);
      end
      tfe_pkg::FmtA4: begin
        a_d = widen4(nib);
      end
      default: begin
        a_d = '0;
      end
    endcase
  end

  always_comb begin
    valid_d   = head_i.valid;
    run_end_d = 1'b1;
    half_d    = 1'b0;
    pop_o     = 1'b0;
    if (head_i.valid) begin
      if (two_pix && !half_q) begin
        run_end_d = 1'b0;
        half_d    = 1'b1;
      end else begin
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_end_q <= run_end_d;
    a_q       <= a_d;
    b_q       <= b_d;
    g_q       <= g_d;
    r_q       <= r_d;
  end

  assign result_valid_o = valid_q;
  assign run_end_o      = run_end_q;
  assign alpha_out_o    = a_q;
  assign blue_out_o     = b_q;
  assign green_out_o    = g_q;
  assign red_out_o      = r_q;

  `TFE_ASSERT(a_half_two_pix, half_q |-> (head_i.valid && two_pix), "stray second half")
  `TFE_ASSERT(a_run_continues, (valid_q && !run_end_q) |=> valid_q, "two pixel run cut short")

endmodule

// ===== rtl/core/texel_format_expander_unit.sv =====
// ---------------------------------------------------------------------------
// texel format expander unit
// unpacks source texels of twelve formats into rgba8 pixels
// ---------------------------------------------------------------------------
// usage:
//   cfg_we_i/cfg_wdata_i write the 4-bit source format while the unit is idle.
//   a texel beat is taken on source_word_i at a clock edge with start_i high
//   and busy_o low. texels of an undefined format are dropped.
//   each pixel shows on the result ports for one cycle with result_valid_o
//   high; run_end_o marks the last pixel of a texel. the receiver cannot stall.
// path: an accepted texel is written into the queue, and its first pixel is
//   then registered in the output stage of the back end before it is shown.
// throughput: one texel per cycle for single-pixel formats while busy_o is
//   low; L4 and A4 give two pixels per texel and hold the back end for
//   both pixels. the output stage emits one pixel per cycle, and the queue
//   between front and back (QueueDepth entries) raises busy_o only when full.
// reset: the format returns to RGBA8, the queue empties, no result is shown.
// ---------------------------------------------------------------------------
module texel_format_expander_unit #(
  parameter int unsigned QueueDepth = tfe_pkg::QueueDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tfe_pkg::FmtW-1:0]  cfg_wdata_i,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [tfe_pkg::WordW-1:0] source_word_i,
  output logic                      result_valid_o,
  output logic [7:0]                alpha_out_o,
  output logic [7:0]                blue_out_o,
  output logic [7:0]                green_out_o,
  output logic [7:0]                red_out_o,
  output logic                      run_end_o
);

  tfe_pkg::push_t push;
  tfe_pkg::head_t head;
  logic           full;
  logic           pop;

  tfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .source_word_i (source_word_i),
    .full_i        (full),
    .busy_o        (busy_o),
    .push_o        (push)
  );

  tfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  tfe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .alpha_out_o    (alpha_out_o),
    .blue_out_o     (blue_out_o),
    .green_out_o    (green_out_o),
    .red_out_o      (red_out_o),
    .run_end_o      (run_end_o)
  );

endmodule
